### rtl/wbs_pkg.sv
package wbs_pkg;

  // field and register widths
  localparam int IMG_W_W    = 11;
  localparam int LEVEL_W    = 8;
  localparam int VEL_W      = 15;
  localparam int OUT_W      = 16;
  localparam int COUNT_W    = 21;
  localparam int SUM_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // accumulator saturation limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  // image size limits
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;

  // register reset values
  localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [IMG_W_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [LEVEL_W-1:0] LEVEL_RST  = 8'd255;
  localparam logic [VEL_W-1:0]   LIN_RST    = 15'd2048;
  localparam logic [VEL_W-1:0]   ANG_RST    = 15'd4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANG = 3'd4;

  // shared unit sizing
  localparam int ALU_W  = 50;
  localparam int MULB_W = 15;
  localparam int QUO_W  = 18;
  localparam int ITER_W = 5;
  localparam int DEN_W  = IMG_W_W + COUNT_W;
  localparam int AREA_W = 2 * IMG_W_W;

  // output saturation magnitudes
  localparam logic [QUO_W-1:0] POS_LIMIT = 18'd32767;
  localparam logic [QUO_W-1:0] NEG_LIMIT = 18'd32768;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] linear_speed;
    logic signed [OUT_W-1:0] angular_rate;
    logic                    target_seen;
  } result_t;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_MUL_LOAD,
    ALU_MUL_STEP,
    ALU_SUB,
    ALU_DIV_LOAD,
    ALU_DIV_STEP
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [ALU_W-1:0]  x;
    logic [ALU_W-1:0]  y;
    logic [MULB_W-1:0] mulb;
  } alu_cmd_t;

  typedef struct packed {
    logic [ALU_W-1:0] acc;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } alu_stat_t;

  // zero reads as one, anything past the limit reads as the limit
  function automatic logic [IMG_W_W-1:0] clamp_dim(logic [IMG_W_W-1:0] v, int hi);
    logic [IMG_W_W-1:0] r;
    if (v == '0) begin
      r = IMG_W_W'(1);
    end else if (int'(v) > hi) begin
      r = IMG_W_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/wbs_accum.sv
module wbs_accum #(
  parameter int MAX_WIDTH = wbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  wbs_pkg::pixel_t                   pixel,
  input  logic [wbs_pkg::LEVEL_W-1:0]       white_level,
  input  logic [wbs_pkg::IMG_W_W-1:0]       width,
  output logic [wbs_pkg::COUNT_W-1:0]       tot_count,
  output logic [wbs_pkg::SUM_W-1:0]         tot_sum
);

  localparam int CW_FULL = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW      = (CW_FULL > wbs_pkg::IMG_W_W) ? wbs_pkg::IMG_W_W : CW_FULL;

  logic [CW-1:0]               col_r, col_nxt;
  logic [wbs_pkg::COUNT_W-1:0] count_r, count_nxt, count_add;
  logic [wbs_pkg::SUM_W-1:0]   sum_r, sum_nxt, sum_add;
  logic [wbs_pkg::COUNT_W-1:0] tot_count_r;
  logic [wbs_pkg::SUM_W-1:0]   tot_sum_r;
  logic [wbs_pkg::IMG_W_W:0]   col_inc;
  logic [wbs_pkg::SUM_W:0]     sum_wide;
  logic                        white;

  // white test and saturating accumulation
  always_comb begin
    white = (pixel.red == white_level) && (pixel.green == white_level) &&
            (pixel.blue == white_level);
    sum_wide = {1'b0, sum_r} + (wbs_pkg::SUM_W+1)'(col_r);
    count_add = count_r;
    sum_add   = sum_r;
    if (white) begin
      if (count_r != wbs_pkg::COUNT_MAX) begin
        count_add = count_r + 1'b1;
      end
      sum_add = sum_wide[wbs_pkg::SUM_W] ? wbs_pkg::SUM_MAX : sum_wide[wbs_pkg::SUM_W-1:0];
    end
  end

  // column counter wraps at the row width
  always_comb begin
    col_inc = (wbs_pkg::IMG_W_W+1)'(col_r) + 1'b1;
    if (col_inc >= {1'b0, width}) begin
      col_nxt = '0;
    end else begin
      col_nxt = col_inc[CW-1:0];
    end
    count_nxt = count_add;
    sum_nxt   = sum_add;
    if (pixel.frame_end) begin
      col_nxt   = '0;
      count_nxt = '0;
      sum_nxt   = '0;
    end
  end

  // running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (accept) begin
      col_r   <= col_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // frame totals held for the sequencer
  always_ff @(posedge clk) begin
    if (accept && pixel.frame_end) begin
      tot_count_r <= count_add;
      tot_sum_r   <= sum_add;
    end
  end

  assign tot_count = tot_count_r;
  assign tot_sum   = tot_sum_r;

endmodule

### rtl/wbs_alu.sv
module wbs_alu (
  input  logic                clk,
  input  wbs_pkg::alu_cmd_t   cmd,
  output wbs_pkg::alu_stat_t  stat
);

  logic [wbs_pkg::ALU_W-1:0]  acc_r, acc_nxt;
  logic [wbs_pkg::ALU_W-1:0]  opa_r, opa_nxt;
  logic [wbs_pkg::MULB_W-1:0] mulb_r, mulb_nxt;
  logic [wbs_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic                       neg_r, neg_nxt;
  logic [wbs_pkg::ALU_W-1:0]  ax, ay, res;
  logic                       sub, carry;

  // the one shared adder/subtractor
  always_comb begin
    ax  = cmd.x;
    ay  = cmd.y;
    sub = 1'b0;
    case (cmd.op)
      wbs_pkg::ALU_MUL_STEP: begin
        ax = acc_r;
        ay = opa_r;
      end
      wbs_pkg::ALU_DIV_STEP: begin
        ax  = acc_r;
        ay  = opa_r;
        sub = 1'b1;
      end
      wbs_pkg::ALU_SUB: begin
        sub = 1'b1;
      end
      default: begin
      end
    endcase
    {carry, res} = {1'b0, ax} + {1'b0, (sub ? ~ay : ay)} + (wbs_pkg::ALU_W+1)'(sub);
  end

  // shift-add multiply, restoring divide and plain subtract
  always_comb begin
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    mulb_nxt = mulb_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    case (cmd.op)
      wbs_pkg::ALU_MUL_LOAD: begin
        acc_nxt  = cmd.x;
        opa_nxt  = cmd.y;
        mulb_nxt = cmd.mulb;
      end
      wbs_pkg::ALU_MUL_STEP: begin
        if (mulb_r[0]) begin
          acc_nxt = res;
        end
        opa_nxt  = opa_r << 1;
        mulb_nxt = mulb_r >> 1;
      end
      wbs_pkg::ALU_SUB: begin
        acc_nxt = res;
        neg_nxt = ~carry;
      end
      wbs_pkg::ALU_DIV_LOAD: begin
        opa_nxt = cmd.y;
        quo_nxt = '0;
      end
      wbs_pkg::ALU_DIV_STEP: begin
        if (carry) begin
          acc_nxt = res;
        end
        quo_nxt = {quo_r[wbs_pkg::QUO_W-2:0], carry};
        opa_nxt = opa_r >> 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    mulb_r <= mulb_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
  end

  assign stat.acc = acc_r;
  assign stat.quo = quo_r;
  assign stat.neg = neg_r;

endmodule

### rtl/wbs_seq.sv
module wbs_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_frame_end,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wbs_pkg::result_t              out_data,
  input  logic [wbs_pkg::IMG_W_W-1:0]   width,
  input  logic [wbs_pkg::IMG_W_W-1:0]   height,
  input  logic [wbs_pkg::VEL_W-1:0]     max_linear,
  input  logic [wbs_pkg::VEL_W-1:0]     max_angular,
  input  logic [wbs_pkg::COUNT_W-1:0]   tot_count,
  input  logic [wbs_pkg::SUM_W-1:0]     tot_sum,
  output wbs_pkg::alu_cmd_t             cmd,
  input  wbs_pkg::alu_stat_t            stat
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_START   = 12'b000000000010,
    S_WC      = 12'b000000000100,
    S_AREA_LD = 12'b000000001000,
    S_AREA    = 12'b000000010000,
    S_DIF     = 12'b000000100000,
    S_NEG     = 12'b000001000000,
    S_MUL_LD  = 12'b000010000000,
    S_MUL     = 12'b000100000000,
    S_DIV_LD  = 12'b001000000000,
    S_DIV     = 12'b010000000000,
    S_RES     = 12'b100000000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [wbs_pkg::ITER_W-1:0]     iter_r, iter_nxt;
  logic                           pass_r, pass_nxt;
  logic                           sign_r, sign_nxt;
  logic                           moving_r, moving_nxt;
  logic [wbs_pkg::DEN_W-1:0]      wc_r, wc_nxt;
  logic [wbs_pkg::AREA_W-1:0]     area_r, area_nxt;
  logic [wbs_pkg::OUT_W-1:0]      ang_r, ang_nxt;
  logic                           out_valid_r, out_valid_nxt;
  wbs_pkg::result_t               out_data_r, out_data_nxt;
  logic [wbs_pkg::DEN_W-1:0]      den;
  logic [wbs_pkg::VEL_W-1:0]      vmax;
  logic [wbs_pkg::QUO_W-1:0]      qs;
  logic [wbs_pkg::OUT_W-1:0]      val;
  logic                           accept;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || !in_frame_end);
  assign accept   = in_valid && in_ready;

  // angular pass divides by w*count, linear pass by w*h
  assign den  = pass_r ? wbs_pkg::DEN_W'(area_r) : wc_r;
  assign vmax = pass_r ? max_linear : max_angular;

  // rounded quotient to signed, saturated velocity
  always_comb begin
    qs = stat.quo;
    if (sign_r) begin
      if (qs > wbs_pkg::NEG_LIMIT) begin
        qs = wbs_pkg::NEG_LIMIT;
      end
      val = wbs_pkg::OUT_W'(wbs_pkg::QUO_W'(0) - qs);
    end else begin
      if (qs > wbs_pkg::POS_LIMIT) begin
        qs = wbs_pkg::POS_LIMIT;
      end
      val = qs[wbs_pkg::OUT_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    pass_nxt      = pass_r;
    sign_nxt      = sign_r;
    moving_nxt    = moving_r;
    wc_nxt        = wc_r;
    area_nxt      = area_r;
    ang_nxt       = ang_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd.op        = wbs_pkg::ALU_IDLE;
    cmd.x         = '0;
    cmd.y         = '0;
    cmd.mulb      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_frame_end) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (tot_count == '0) begin
          // no target this frame: stop once if the robot was driving
          if (moving_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            moving_nxt    = 1'b0;
          end
          state_nxt = S_IDLE;
        end else begin
          moving_nxt = 1'b1;
          pass_nxt   = 1'b0;
          cmd.op     = wbs_pkg::ALU_MUL_LOAD;
          cmd.y      = wbs_pkg::ALU_W'(tot_count);
          cmd.mulb   = wbs_pkg::MULB_W'(width);
          iter_nxt   = wbs_pkg::ITER_W'(wbs_pkg::IMG_W_W - 1);
          state_nxt  = S_WC;
        end
      end
      S_WC, S_AREA, S_MUL: begin
        cmd.op   = wbs_pkg::ALU_MUL_STEP;
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          case (state_r)
            S_WC:    state_nxt = S_AREA_LD;
            S_AREA:  state_nxt = S_DIF;
            default: state_nxt = S_DIV_LD;
          endcase
        end
      end
      S_AREA_LD: begin
        wc_nxt    = stat.acc[wbs_pkg::DEN_W-1:0];
        cmd.op    = wbs_pkg::ALU_MUL_LOAD;
        cmd.y     = wbs_pkg::ALU_W'(height);
        cmd.mulb  = wbs_pkg::MULB_W'(width);
        iter_nxt  = wbs_pkg::ITER_W'(wbs_pkg::IMG_W_W - 1);
        state_nxt = S_AREA;
      end
      S_DIF: begin
        cmd.op = wbs_pkg::ALU_SUB;
        if (pass_r) begin
          cmd.x = wbs_pkg::ALU_W'(area_r);
          cmd.y = wbs_pkg::ALU_W'({tot_count, 1'b0});
        end else begin
          area_nxt = stat.acc[wbs_pkg::AREA_W-1:0];
          cmd.x    = wbs_pkg::ALU_W'(wc_r);
          cmd.y    = wbs_pkg::ALU_W'({tot_sum, 1'b0});
        end
        state_nxt = S_NEG;
      end
      S_NEG: begin
        // keep the sign, go on with the magnitude
        sign_nxt = stat.neg;
        if (stat.neg) begin
          cmd.op = wbs_pkg::ALU_SUB;
          cmd.y  = stat.acc;
        end
        state_nxt = S_MUL_LD;
      end
      S_MUL_LD: begin
        cmd.op    = wbs_pkg::ALU_MUL_LOAD;
        cmd.x     = wbs_pkg::ALU_W'(den >> 1);
        cmd.y     = stat.acc;
        cmd.mulb  = vmax;
        iter_nxt  = wbs_pkg::ITER_W'(wbs_pkg::MULB_W - 1);
        state_nxt = S_MUL;
      end
      S_DIV_LD: begin
        cmd.op    = wbs_pkg::ALU_DIV_LOAD;
        cmd.y     = wbs_pkg::ALU_W'(den) << (wbs_pkg::QUO_W - 1);
        iter_nxt  = wbs_pkg::ITER_W'(wbs_pkg::QUO_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op   = wbs_pkg::ALU_DIV_STEP;
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (pass_r) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.linear_speed = val;
          out_data_nxt.angular_rate = ang_r;
          out_data_nxt.target_seen  = 1'b1;
          state_nxt                 = S_IDLE;
        end else begin
          ang_nxt   = val;
          pass_nxt  = 1'b1;
          state_nxt = S_DIF;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      moving_r    <= moving_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working values and result register
  always_ff @(posedge clk) begin
    iter_r     <= iter_nxt;
    pass_r     <= pass_nxt;
    sign_r     <= sign_nxt;
    wc_r       <= wc_nxt;
    area_r     <= area_nxt;
    ang_r      <= ang_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/white_blob_steering.sv
// channel   dir  handshake          payload
// in_       in   in_valid/in_ready  pixel_t: red, green, blue, frame_end
// out_      out  out_valid/out_ready result_t: linear_speed, angular_rate, target_seen
// cfg_      in   cfg_we             cfg_index, cfg_wdata (write only)
//
// an ordinary pixel is taken whenever the sequencer is idle, so pixels stream at one per clock while it is idle
// a frame-end pixel holds in_ready low while the sequencer works when white pixels were seen
// (shared 50-bit adder: 11 + 11 multiply bits, then per velocity 15 multiply bits and
// 18 quotient bits, plus load steps), and only through the start state when none were seen
// a frame-end pixel waits while an earlier command is still not taken
// synchronous active-low reset clears counters, sequencer and output valid

module white_blob_steering #(
  parameter int MAX_WIDTH = wbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wbs_pkg::pixel_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wbs_pkg::result_t                 out_data,
  input  logic                             cfg_we,
  input  logic [wbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [wbs_pkg::IMG_W_W-1:0] width_r, height_r, width_eff, height_eff;
  logic [wbs_pkg::LEVEL_W-1:0] level_r;
  logic [wbs_pkg::VEL_W-1:0]   max_lin_r, max_ang_r;
  logic [wbs_pkg::COUNT_W-1:0] tot_count;
  logic [wbs_pkg::SUM_W-1:0]   tot_sum;
  wbs_pkg::alu_cmd_t           cmd;
  wbs_pkg::alu_stat_t          stat;
  logic                        in_accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= wbs_pkg::WIDTH_RST;
      height_r  <= wbs_pkg::HEIGHT_RST;
      level_r   <= wbs_pkg::LEVEL_RST;
      max_lin_r <= wbs_pkg::LIN_RST;
      max_ang_r <= wbs_pkg::ANG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wbs_pkg::REG_WIDTH:   width_r   <= cfg_wdata[wbs_pkg::IMG_W_W-1:0];
        wbs_pkg::REG_HEIGHT:  height_r  <= cfg_wdata[wbs_pkg::IMG_W_W-1:0];
        wbs_pkg::REG_LEVEL:   level_r   <= cfg_wdata[wbs_pkg::LEVEL_W-1:0];
        wbs_pkg::REG_MAX_LIN: max_lin_r <= cfg_wdata[wbs_pkg::VEL_W-1:0];
        wbs_pkg::REG_MAX_ANG: max_ang_r <= cfg_wdata[wbs_pkg::VEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // image size as used, limited to the supported range
  assign width_eff  = wbs_pkg::clamp_dim(width_r, MAX_WIDTH);
  assign height_eff = wbs_pkg::clamp_dim(height_r, wbs_pkg::MAX_HEIGHT);
  assign in_accept  = in_valid && in_ready;

  wbs_accum #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .pixel       (in_data),
    .white_level (level_r),
    .width       (width_eff),
    .tot_count   (tot_count),
    .tot_sum     (tot_sum)
  );

  wbs_alu u_alu (
    .clk  (clk),
    .cmd  (cmd),
    .stat (stat)
  );

  wbs_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_frame_end (in_data.frame_end),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .width        (width_eff),
    .height       (height_eff),
    .max_linear   (max_lin_r),
    .max_angular  (max_ang_r),
    .tot_count    (tot_count),
    .tot_sum      (tot_sum),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

### rtl/wbs_checker.sv
module wbs_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input wbs_pkg::pixel_t  in_data,
  input logic             out_valid,
  input logic             out_ready,
  input wbs_pkg::result_t out_data
);

  // a waiting command holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // a frame end makes the block busy for at least the next cycle
  a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.frame_end |=> !in_ready)
    else $error("input taken right after a frame end transfer");

  // a frame end is only taken with the result slot free
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.frame_end |-> !out_valid)
    else $error("frame end taken while a result is pending");

  // a new command only appears after the block was busy
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a frame end being processed");

  // a stop command carries zero velocities
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.target_seen |->
      out_data.linear_speed == '0 && out_data.angular_rate == '0)
    else $error("stop command with nonzero velocity");

endmodule

bind white_blob_steering wbs_checker u_wbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
